FILE: src/bps_pkg.sv
package bps_pkg;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ALNUM = 2'd1,
    MODE_UTF8  = 2'd2
  } run_mode_e;

  localparam logic [7:0] Utf8LeadMin = 8'h80;
  localparam logic [7:0] Mask2       = 8'hE0;
  localparam logic [7:0] Lead2       = 8'hC0;
  localparam logic [7:0] Mask3       = 8'hF0;
  localparam logic [7:0] Lead3       = 8'hE0;
  localparam logic [7:0] Mask4       = 8'hF8;
  localparam logic [7:0] Lead4       = 8'hF0;

  // one queue entry: first result, optional second result, text end on the last of them
  typedef struct packed {
    logic [7:0] byte0;
    logic       start0;
    logic       has1;
    logic [7:0] byte1;
    logic       start1;
    logic       last;
  } entry_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= Utf8LeadMin) begin
      if ((b & Mask2) == Lead2) n = 2'd1;
      else if ((b & Mask3) == Lead3) n = 2'd2;
      else if ((b & Mask4) == Lead4) n = 2'd3;
    end
    return n;
  endfunction

endpackage

FILE: src/bps_front.sv
module bps_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      text_byte_i,
  input  logic            text_last_i,
  input  logic            q_full_i,
  output logic            push_o,
  output bps_pkg::entry_t push_entry_o
);
  import bps_pkg::*;

  logic       held_valid_q, held_valid_d;
  logic [7:0] held_space_q, held_space_d;
  logic       held_first_q, held_first_d;
  run_mode_e  mode_q, mode_d;
  logic [1:0] remain_q, remain_d;
  logic       acc;
  logic       ws, alnum, hi_bit, cont;
  entry_t     e;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign ws         = is_ws(text_byte_i);
  assign alnum      = is_alnum(text_byte_i);
  assign hi_bit     = text_byte_i[7];
  assign cont       = ((mode_q == MODE_ALNUM) && alnum) || ((mode_q == MODE_UTF8) && hi_bit);

  always_comb begin
    held_valid_d = held_valid_q;
    held_space_d = held_space_q;
    held_first_d = held_first_q;
    mode_d       = mode_q;
    remain_d     = remain_q;
    push_o       = 1'b0;
    e            = '0;
    if (acc) begin
      priority if (remain_q != 2'd0) begin
        // owed sequence bytes join the piece whatever they are
        remain_d = remain_q - 2'd1;
        push_o   = 1'b1;
        e.byte0  = text_byte_i;
      end else if (ws) begin
        mode_d = MODE_NONE;
        if (held_valid_q) begin
          push_o   = 1'b1;
          e.byte0  = held_space_q;
          e.start0 = held_first_q;
          if (text_last_i) begin
            e.has1   = 1'b1;
            e.byte1  = text_byte_i;
            e.start1 = 1'b1;
          end
        end else if (text_last_i) begin
          push_o   = 1'b1;
          e.byte0  = text_byte_i;
          e.start0 = 1'b1;
        end
        if (!text_last_i) begin
          held_valid_d = 1'b1;
          held_space_d = text_byte_i;
          held_first_d = !held_valid_q;
        end
      end else begin
        push_o = 1'b1;
        if (held_valid_q) begin
          // held whitespace opens the piece, this byte continues it
          e.byte0      = held_space_q;
          e.start0     = 1'b1;
          e.has1       = 1'b1;
          e.byte1      = text_byte_i;
          held_valid_d = 1'b0;
          held_first_d = 1'b0;
          held_space_d = 8'h00;
        end else begin
          e.byte0  = text_byte_i;
          e.start0 = !cont;
        end
        if (alnum) begin
          mode_d = MODE_ALNUM;
        end else if (hi_bit) begin
          mode_d   = MODE_UTF8;
          remain_d = extra_bytes(text_byte_i);
        end else begin
          mode_d = MODE_NONE;
        end
      end
      if (text_last_i) begin
        e.last       = 1'b1;
        held_valid_d = 1'b0;
        held_space_d = 8'h00;
        held_first_d = 1'b0;
        mode_d       = MODE_NONE;
        remain_d     = 2'd0;
      end
    end
  end

  assign push_entry_o = e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_space_q <= 8'h00;
      held_first_q <= 1'b0;
      mode_q       <= MODE_NONE;
      remain_q     <= 2'd0;
    end else begin
      held_valid_q <= held_valid_d;
      held_space_q <= held_space_d;
      held_first_q <= held_first_d;
      mode_q       <= mode_d;
      remain_q     <= remain_d;
    end
  end

endmodule

FILE: src/bps_fifo.sv
module bps_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bps_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output bps_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import bps_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/bps_back.sv
module bps_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bps_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            piece_start_o,
  output logic            text_end_o
);
  import bps_pkg::*;

  logic       sub_q, sub_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       start_q, start_d;
  logic       end_q, end_d;
  logic       load;

  // output register frees when empty or when its transfer completes
  assign load = !valid_q || !out_stall_i;

  always_comb begin
    sub_d   = sub_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    start_d = start_q;
    end_d   = end_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (sub_q) begin
          byte_d  = head_i.byte1;
          start_d = head_i.start1;
          end_d   = head_i.last;
          sub_d   = 1'b0;
          pop_o   = 1'b1;
        end else begin
          byte_d  = head_i.byte0;
          start_d = head_i.start0;
          end_d   = head_i.last && !head_i.has1;
          sub_d   = head_i.has1;
          pop_o   = !head_i.has1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
    end_q   <= end_d;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign piece_start_o = start_q;
  assign text_end_o    = end_q;

endmodule

FILE: src/bpe_pretokenizer_splitter.sv
// Byte-level pre-tokenizer splitter. Text bytes enter on the input channel
// (in_valid_i / in_stall_o, text_byte_i, text_last_i) and leave in the same
// order on the output channel (out_valid_o / out_stall_i) tagged with
// piece_start_o, and text_end_o on the final byte of each text.
// The front classifies each byte and tracks the open piece; whitespace is
// held back one byte. Results go into a QueueDepth-entry queue that the back
// drains through a registered output stage.
// Throughput: one byte per cycle while the queue is not full. A byte that
// follows held whitespace yields two results, which the back sends one at
// a time; the held byte itself yielded none, so the queue absorbs the
// difference. A result passes through the queue and the output register
// before it is valid; a held whitespace byte appears only after the next
// byte (or at text end). Reset clears the held byte, the run state and the
// queue; nothing is pending afterwards. When the receiver stalls, the output
// holds steady and the queue fills; in_stall_o rises once the queue is full.
module bpe_pretokenizer_splitter #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       text_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       piece_start_o,
  output logic       text_end_o
);
  import bps_pkg::*;

  logic   push, pop, q_empty, q_full;
  entry_t push_entry, head;

  bps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .text_last_i  (text_last_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  bps_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  bps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .piece_start_o (piece_start_o),
    .text_end_o    (text_end_o)
  );

endmodule

FILE: tb/bpe_pretokenizer_splitter_tb.sv
module bpe_pretokenizer_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int DirRows = 27;
  localparam int RandItems = 400;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       starts;
    logic       ends;
  } piece_t;

  typedef struct packed {
    logic [7:0] tbyte;
    logic       tlast;
    logic       typed;   // expected result written in the row
    logic       t_start;
    logic       t_end;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i   = 8'h00;
  logic       text_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic       piece_start_o;
  logic       text_end_o;

  // splitter state as predicted
  logic       held_vld   = 1'b0;
  logic [7:0] held_byte  = 8'h00;
  logic       held_first = 1'b0;
  run_mode_e  open_mode  = MODE_NONE;
  logic [1:0] seq_owed   = 2'd0;

  piece_t     pieces_due[$];
  logic [7:0] text_q[$];
  stim_row_t  dir_rows[DirRows];
  int         err_cnt  = 0;
  int         sent_cnt = 0;
  int         got_cnt  = 0;

  bpe_pretokenizer_splitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .text_last_i  (text_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .piece_start_o(piece_start_o),
    .text_end_o   (text_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void due_append(input piece_t p);
    pieces_due.insert(pieces_due.size(), p);
  endfunction

  function automatic void text_append(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic is_space_byte(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic [1:0] utf8_tail_len(input logic [7:0] b);
    casez (b)
      8'b110?????: return 2'd1;
      8'b1110????: return 2'd2;
      8'b11110???: return 2'd3;
      default:     return 2'd0;
    endcase
  endfunction

  task automatic open_piece(input logic [7:0] b);
    if (is_word_byte(b)) begin
      open_mode = MODE_ALNUM;
    end else if (b >= Utf8LeadMin) begin
      open_mode = MODE_UTF8;
      seq_owed  = utf8_tail_len(b);
    end else begin
      open_mode = MODE_NONE;
    end
  endtask

  // Works out the results of one byte; typed rows replace them by the row's own.
  task automatic predict_split(input logic [7:0] b, input logic l, input logic typed,
                               input logic t_start, input logic t_end);
    piece_t res[2];
    int     n;
    logic   first;
    logic   cont;
    n     = 0;
    first = 1'b1;
    if (seq_owed != 2'd0) begin
      // owed sequence bytes ride along whatever they are
      seq_owed = seq_owed - 2'd1;
      res[n++] = '{b, 1'b0, 1'b0};
    end else if (is_space_byte(b)) begin
      open_mode = MODE_NONE;
      if (held_vld) begin
        res[n++] = '{held_byte, held_first, 1'b0};
        first = 1'b0;
      end
      if (l) begin
        res[n++] = '{b, 1'b1, 1'b0};
      end else begin
        held_vld   = 1'b1;
        held_byte  = b;
        held_first = first;
      end
    end else if (held_vld) begin
      res[n++]   = '{held_byte, 1'b1, 1'b0};
      res[n++]   = '{b, 1'b0, 1'b0};
      held_vld   = 1'b0;
      held_first = 1'b0;
      held_byte  = 8'h00;
      open_piece(b);
    end else begin
      cont = (open_mode == MODE_ALNUM && is_word_byte(b)) ||
             (open_mode == MODE_UTF8 && b >= Utf8LeadMin);
      res[n++] = '{b, !cont, 1'b0};
      open_piece(b);
    end
    if (l) begin
      if (n > 0) res[n-1].ends = 1'b1;
      held_vld   = 1'b0;
      held_byte  = 8'h00;
      held_first = 1'b0;
      open_mode  = MODE_NONE;
      seq_owed   = 2'd0;
    end
    if (typed) begin
      due_append(piece_t'{b, t_start, t_end});
    end else begin
      for (int k = 0; k < n; k++) due_append(res[k]);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input logic t_start, input logic t_end);
    int gap;
    gap = (sent_cnt % 100 >= 70) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    text_last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    predict_split(b, l, typed, t_start, t_end);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pieces_due.size() != 0);
  endtask

  function automatic logic [7:0] pick_word();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 127)); while (is_word_byte(b) || is_space_byte(b));
    return b;
  endfunction

  // Mostly well-formed text; a stray byte now and then, and the cut at the
  // end may split a UTF-8 sequence.
  task automatic build_text();
    int len;
    int kind;
    int tail;
    text_q.delete();
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
    while (text_q.size() < len) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        text_append(pick_word());
      end else if (kind <= 5) begin
        text_append(pick_space());
      end else if (kind == 6) begin
        text_append(pick_punct());
      end else if (kind <= 8) begin
        tail = $urandom_range(0, 3);
        case (tail)
          0: text_append(($urandom_range(0, 1) == 1) ?
                         8'($urandom_range(8'h80, 8'hBF)) :
                         8'($urandom_range(8'hF8, 8'hFF)));
          1: text_append({3'b110, 5'($urandom)});
          2: text_append({4'b1110, 4'($urandom)});
          default: text_append({5'b11110, 3'($urandom)});
        endcase
        repeat (tail) begin
          text_append(($urandom_range(0, 9) == 0) ? 8'($urandom) :
                      {2'b10, 6'($urandom)});
        end
      end else begin
        text_append(8'($urandom));
      end
    end
    while (text_q.size() > len) void'(text_q.pop_back());
  endtask

  initial begin : drain_results
    int     hold;
    piece_t want;
    @(posedge rst_ni);
    forever begin
      hold = (got_cnt % 90 >= 60) ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got_cnt++;
      if (pieces_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result: byte %h start %b end %b",
                   out_byte_o, piece_start_o, text_end_o);
      end else begin
        want = pieces_due.pop_front();
        if (out_byte_o !== want.pbyte || piece_start_o !== want.starts ||
            text_end_o !== want.ends) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d: expected byte %h start %b end %b, got byte %h start %b end %b",
                     got_cnt, want.pbyte, want.starts, want.ends,
                     out_byte_o, piece_start_o, text_end_o);
        end
      end
    end
  end

  initial begin : feed_text
    stim_row_t row;
    bit        paused;
    //            byte   last  typed start end
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0},  // punctuation right after reset
      '{8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h30, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h20, 1'b0, 1'b0, 1'b0, 1'b0},  // held, nothing out
      '{8'h20, 1'b0, 1'b0, 1'b0, 1'b0},  // releases first of run
      '{8'h09, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h7A, 1'b0, 1'b0, 1'b0, 1'b0},  // held byte plus this one
      '{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h0A, 1'b0, 1'b0, 1'b0, 1'b0},  // owed byte, whitespace ignored
      '{8'hE2, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h41, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h20, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h0D, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0},  // stray high byte, length one
      '{8'h2E, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h0D, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h7F, 1'b1, 1'b0, 1'b0, 1'b0},  // held byte released at text end
      '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1},
      '{8'h20, 1'b1, 1'b1, 1'b1, 1'b1},
      '{8'h0A, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h20, 1'b1, 1'b0, 1'b0, 1'b0},  // two spaces, both start pieces
      '{8'hE0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h41, 1'b1, 1'b0, 1'b0, 1'b0}   // sequence cut off by text end
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_byte(row.tbyte, row.tlast, row.typed, row.t_start, row.t_end);
    end
    wait_drained();
    paused = 1'b0;
    while (sent_cnt < DirRows + RandItems) begin
      build_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, 1'b0, 1'b0, 1'b0);
      if (!paused && sent_cnt >= DirRows + RandItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
